/* sv/ptb_pkg.sv */
// Shared types and constants for the pausable time base.
// Used by the converter and the top level.
package ptb_pkg;

  localparam int TICK_W  = 64;
  localparam int RATE_W  = 40;
  localparam int COUNT_W = 32;
  localparam int AMT_W   = 32;
  localparam int US_W    = 64;

  localparam logic [RATE_W-1:0] MICROS_PER_SECOND = RATE_W'(1000000);
  localparam logic [RATE_W-1:0] TICK_RATE_RESET   = RATE_W'(10000000);

  // Configuration register indexes.
  localparam logic CFG_TICK_RATE    = 1'b0;
  localparam logic CFG_CONVERT_MODE = 1'b1;

  // Input command codes.
  localparam logic CMD_ADVANCE = 1'b0;
  localparam logic CMD_RESTART = 1'b1;

  typedef struct packed {
    logic              command;
    logic [AMT_W-1:0]  amount;
    logic              advance_virtual;
  } request_t;

  typedef struct packed {
    logic [US_W-1:0]    now_micros;
    logic [US_W-1:0]    before_micros;
    logic [US_W-1:0]    virtual_micros;
    logic [US_W-1:0]    before_virtual_micros;
    logic [COUNT_W-1:0] frame_count;
    logic [COUNT_W-1:0] virtual_frame_count;
  } result_t;

  typedef struct packed {
    logic start;
    logic mode;
  } conv_ctrl_t;

endpackage

/* sv/ptb_stream_if.sv */
// Valid/ready stream channel with a typed payload.
// Depends on nothing; the payload type comes in as a parameter.
interface ptb_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* sv/ptb_convert.sv */
// Tick-to-microsecond converter: bit-serial multiply, then restoring divide.
// Depends on ptb_pkg for widths and the microseconds-per-second constant.
module ptb_convert (
  input  logic                        clk,
  input  logic                        rst,
  input  ptb_pkg::conv_ctrl_t         ctrl,
  input  logic [ptb_pkg::TICK_W-1:0]  ticks,
  input  logic [ptb_pkg::RATE_W-1:0]  rate,
  output logic                        busy,
  output logic [ptb_pkg::US_W-1:0]    micros
);

  localparam int TW     = ptb_pkg::TICK_W;
  localparam int RW     = ptb_pkg::RATE_W;
  localparam int PROD_W = TW + RW;
  localparam int STEP_W = $clog2(PROD_W);
  localparam logic [STEP_W-1:0] MUL_LAST = STEP_W'(RW - 1);
  localparam logic [STEP_W-1:0] DIV_LAST = STEP_W'(PROD_W - 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MUL  = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;

  logic [1:0]        state;
  logic [STEP_W-1:0] count;
  logic [PROD_W-1:0] prod;
  logic [TW-1:0]     mcand;
  logic [RW-1:0]     divisor;
  logic [RW-1:0]     rem;

  logic [TW:0]   mul_sum;
  logic [RW:0]   trial;
  logic [RW:0]   diff;
  logic          fits;
  logic [RW-1:0] rem_next;

  // The multiplier sits in the low bits of prod and is shifted out LSB first
  // while the partial sums come in from the top.
  always_comb begin
    mul_sum  = {1'b0, prod[PROD_W-1:RW]} + {1'b0, (prod[0] ? mcand : {TW{1'b0}})};
    trial    = {rem, prod[PROD_W-1]};
    diff     = trial - {1'b0, divisor};
    fits     = (trial >= {1'b0, divisor});
    rem_next = fits ? diff[RW-1:0] : trial[RW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (ctrl.start) begin
            mcand   <= ticks;
            prod    <= {{TW{1'b0}}, (ctrl.mode ? rate : ptb_pkg::MICROS_PER_SECOND)};
            divisor <= ctrl.mode ? ptb_pkg::MICROS_PER_SECOND : rate;
            count   <= '0;
            state   <= S_MUL;
          end
        end
        S_MUL: begin
          prod <= {mul_sum, prod[RW-1:1]};
          if (count == MUL_LAST) begin
            count <= '0;
            rem   <= '0;
            state <= S_DIV;
          end else begin
            count <= count + 1'b1;
          end
        end
        S_DIV: begin
          // Dividend bits leave at the top, quotient bits enter at the bottom.
          prod <= {prod[PROD_W-2:0], fits};
          rem  <= rem_next;
          if (count == DIV_LAST) begin
            state <= S_IDLE;
          end else begin
            count <= count + 1'b1;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign busy   = (state != S_IDLE);
  assign micros = (divisor == '0) ? {ptb_pkg::US_W{1'b1}} : prod[ptb_pkg::US_W-1:0];

endmodule

/* sv/pausable_time_base.sv */
// Pausable time base: real and virtual tick totals turned into microseconds.
// An accepted advance starts the real converter, and the virtual one when virtual
// time advances; each runs 40 multiply steps and 104 divide steps, then the new
// totals are loaded and the result is presented. A restart skips the converters.
// One request is in work at a time.
// Synchronous reset clears all counts and restores the register defaults.
module pausable_time_base (
  input  logic                        clk,
  input  logic                        rst,
  ptb_stream_if.sink                  request,
  ptb_stream_if.source                result,
  input  logic                        cfg_write,
  input  logic                        cfg_index,
  input  logic [ptb_pkg::RATE_W-1:0]  cfg_data
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_CONV   = 2'd1;
  localparam logic [1:0] ST_FINISH = 2'd2;

  logic [1:0] state;

  logic [ptb_pkg::RATE_W-1:0]  tick_rate;
  logic                        convert_mode;

  logic [ptb_pkg::TICK_W-1:0]  real_ticks;
  logic [ptb_pkg::TICK_W-1:0]  pausable_ticks;
  logic [ptb_pkg::US_W-1:0]    real_us;
  logic [ptb_pkg::US_W-1:0]    prior_real_us;
  logic [ptb_pkg::US_W-1:0]    pausable_us;
  logic [ptb_pkg::US_W-1:0]    prior_pausable_us;
  logic [ptb_pkg::COUNT_W-1:0] frames;
  logic [ptb_pkg::COUNT_W-1:0] pausable_frames;
  logic                        virt_run;

  ptb_pkg::result_t out_item;
  logic             out_valid;

  logic                        accept;
  logic                        advance;
  logic [ptb_pkg::TICK_W-1:0]  real_ticks_next;
  logic [ptb_pkg::TICK_W-1:0]  pausable_ticks_next;
  ptb_pkg::conv_ctrl_t         real_ctrl;
  ptb_pkg::conv_ctrl_t         virt_ctrl;
  logic                        real_busy;
  logic                        virt_busy;
  logic [ptb_pkg::US_W-1:0]    real_micros;
  logic [ptb_pkg::US_W-1:0]    virt_micros;

  assign request.ready = (state == ST_IDLE);
  assign accept        = request.valid && request.ready;
  assign advance       = accept && (request.data.command == ptb_pkg::CMD_ADVANCE);

  assign real_ticks_next     = real_ticks +
                               ptb_pkg::TICK_W'(request.data.amount);
  assign pausable_ticks_next = pausable_ticks +
                               ptb_pkg::TICK_W'(request.data.amount);

  assign real_ctrl = '{start: advance, mode: convert_mode};
  assign virt_ctrl = '{start: advance && request.data.advance_virtual, mode: convert_mode};

  ptb_convert u_real_conv (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (real_ctrl),
    .ticks  (real_ticks_next),
    .rate   (tick_rate),
    .busy   (real_busy),
    .micros (real_micros)
  );

  ptb_convert u_virt_conv (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (virt_ctrl),
    .ticks  (pausable_ticks_next),
    .rate   (tick_rate),
    .busy   (virt_busy),
    .micros (virt_micros)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_rate    <= ptb_pkg::TICK_RATE_RESET;
      convert_mode <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        ptb_pkg::CFG_TICK_RATE:    tick_rate    <= cfg_data;
        ptb_pkg::CFG_CONVERT_MODE: convert_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= ST_IDLE;
      out_valid         <= 1'b0;
      virt_run          <= 1'b0;
      real_ticks        <= '0;
      pausable_ticks    <= '0;
      real_us           <= '0;
      prior_real_us     <= '0;
      pausable_us       <= '0;
      prior_pausable_us <= '0;
      frames            <= '0;
      pausable_frames   <= '0;
    end else begin
      if (state == ST_FINISH && (!out_valid || result.ready)) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            if (request.data.command == ptb_pkg::CMD_RESTART) begin
              real_ticks        <= '0;
              pausable_ticks    <= '0;
              real_us           <= '0;
              prior_real_us     <= '0;
              pausable_us       <= '0;
              prior_pausable_us <= '0;
              frames            <= '0;
              pausable_frames   <= '0;
              state             <= ST_FINISH;
            end else begin
              // The virtual prior value is copied even while virtual time is paused.
              real_ticks        <= real_ticks_next;
              prior_real_us     <= real_us;
              prior_pausable_us <= pausable_us;
              frames            <= frames + 1'b1;
              virt_run          <= request.data.advance_virtual;
              if (request.data.advance_virtual) begin
                pausable_ticks  <= pausable_ticks_next;
                pausable_frames <= pausable_frames + 1'b1;
              end
              state <= ST_CONV;
            end
          end
        end
        ST_CONV: begin
          if (!real_busy && !virt_busy) begin
            real_us <= real_micros;
            if (virt_run) begin
              pausable_us <= virt_micros;
            end
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (!out_valid || result.ready) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FINISH && (!out_valid || result.ready)) begin
      out_item.now_micros            <= real_us;
      out_item.before_micros         <= prior_real_us;
      out_item.virtual_micros        <= pausable_us;
      out_item.before_virtual_micros <= prior_pausable_us;
      out_item.frame_count           <= frames;
      out_item.virtual_frame_count   <= pausable_frames;
    end
  end

  assign result.valid = out_valid;
  assign result.data  = out_item;

  // A new request is only taken once both converters are free.
  a_idle_conv_free: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> (!real_busy && !virt_busy))
    else $error("request taken while a converter is busy");

  // A restart clears the totals and frame counts on the next edge.
  a_restart_clears: assert property (@(posedge clk) disable iff (rst)
    (accept && request.data.command == ptb_pkg::CMD_RESTART) |=>
      (real_ticks == '0 && pausable_ticks == '0 && frames == '0 && pausable_frames == '0))
    else $error("restart did not clear the counts");

  // Finishing with a free output slot always presents a result.
  a_finish_loads: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FINISH && (!out_valid || result.ready)) |=> (out_valid && state == ST_IDLE))
    else $error("finished request was not presented");

endmodule
